>>> hdl/ffha_pkg.sv
// package for the first-fit heap allocator: sizes, types and codes
package ffha_pkg;

  localparam int unsigned HeapBytes   = 1048576;
  localparam int unsigned AlignBytes  = 8;
  localparam int unsigned HeaderBytes = 24;
  localparam int unsigned MaxBlocks   = 1024;

  localparam int unsigned IdxW   = $clog2(MaxBlocks);
  localparam int unsigned CntW   = IdxW + 1;
  localparam int unsigned StartW = 21;
  localparam int unsigned LenW   = 20;
  localparam int unsigned EntryW = StartW + LenW + 1;
  localparam int unsigned AddrW  = 20;
  localparam int unsigned SizeW  = 21;
  localparam int unsigned AlignW = (AlignBytes > 1) ? $clog2(AlignBytes) : 1;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NULL    = 2'd1,
    ST_NOMEM   = 2'd2,
    ST_UNKNOWN = 2'd3
  } status_e;

  typedef struct packed {
    logic [StartW-1:0] start;
    logic [LenW-1:0]   len;
    logic              free;
  } entry_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_A_RD, S_A_WT, S_A_CHK,
    S_A_SPLIT, S_A_SH_RD, S_A_SH_WT, S_A_SH_WR, S_A_INS,
    S_A_APP,
    S_F_RD, S_F_WT, S_F_CHK,
    S_M_RD, S_M_WT, S_M_CHK,
    S_R_RD, S_R_WT, S_R_WR,
    S_P_RD, S_P_WT, S_P_CHK,
    S_DONE
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic load;      // capture request
    logic idx_clr;   // idx := 0
    logic idx_inc;
    logic idx_dec;
    logic idx_pos;   // idx := pos
    logic idx_cnt;   // idx := count
    logic pos_idx;   // pos := idx
    logic pos_prev;  // pos := pos - 1
    logic rd_idx;    // read at idx
    logic rd_idx1;   // read at idx + 1
    logic hold_rd;   // hold read word as current
    logic wr_alloc;  // write pos: used, need length
    logic wr_mark;   // write pos: used, full length
    logic wr_free;   // write pos: marked free
    logic wr_shift;  // write idx+1 := read word
    logic wr_rem;    // write pos+1 := remainder block
    logic wr_app;    // write count := new block
    logic wr_grow;   // write pos: absorb read successor
    logic wr_down;   // write idx := read word
    logic cnt_inc;
    logic cnt_dec;
    logic end_add;
    logic res_set;   // result := payload of pos
    logic done;
    status_e status;
  } ctl_t;

  // datapath to controller
  typedef struct packed {
    logic is_free_req;
    logic zero_size;
    logic null_addr;
    logic idx_at_cnt;   // idx == count
    logic idx1_at_cnt;  // idx + 1 >= count
    logic idx_gt_pos;   // idx > pos + 1 (shift still needed)
    logic fits;
    logic can_split;
    logic cnt_full;
    logic app_ok;
    logic addr_hit;
    logic rd_free;
    logic pos_zero;
  } sts_t;

endpackage

>>> hdl/ffha_ram.sv
// generic single-port ram with registered read
module ffha_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  // write or read one word a cycle
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_o <= mem[addr_i];
  end

endmodule

>>> hdl/ffha_datapath.sv
// datapath: block table, counters, request registers and compares
module ffha_datapath
  import ffha_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             req_type_i,
  input  logic [SizeW-1:0] req_size_i,
  input  logic [AddrW-1:0] req_addr_i,
  input  ctl_t             ctl_i,
  output sts_t             sts_o,
  output logic [AddrW-1:0] result_addr_o
);

  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [StartW-1:0] end_q, end_d;
  logic [CntW-1:0]   idx_q, idx_d;
  logic [CntW-1:0]   pos_q, pos_d;
  logic              type_q;
  logic [SizeW:0]    need_q;
  logic [AddrW-1:0]  addr_q;
  logic              zero_q;
  entry_t            cur_q;
  logic [AddrW-1:0]  res_q;

  entry_t          rdata, wdata;
  logic            we;
  logic [CntW-1:0] ram_addr;
  logic [SizeW:0]  need_c;
  logic [SizeW:0]  size_ext;

  // round size up to the alignment
  assign size_ext = {1'b0, req_size_i};
  assign need_c = (size_ext + SizeW'(AlignBytes - 1)) & ~(SizeW+1)'(AlignBytes - 1);

  // request and result registers
  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      type_q <= req_type_i;
      need_q <= need_c;
      addr_q <= req_addr_i;
      zero_q <= (req_size_i == '0);
    end
    // current block follows its merged length
    if (ctl_i.hold_rd) begin
      cur_q <= rdata;
    end else if (ctl_i.wr_grow) begin
      cur_q <= wdata;
    end
    if (ctl_i.load) begin
      res_q <= '0;
    end else if (ctl_i.res_set) begin
      res_q <= AddrW'({3'b0, cur_q.start} + (StartW+3)'(HeaderBytes));
    end else if (ctl_i.wr_app) begin
      res_q <= AddrW'({3'b0, end_q} + (StartW+3)'(HeaderBytes));
    end
  end

  // control counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      end_q <= '0;
      idx_q <= '0;
      pos_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      end_q <= end_d;
      idx_q <= idx_d;
      pos_q <= pos_d;
    end
  end

  // next values of counters
  always_comb begin
    cnt_d = cnt_q;
    if (ctl_i.cnt_inc) cnt_d = cnt_q + 1'b1;
    if (ctl_i.cnt_dec) cnt_d = cnt_q - 1'b1;
    end_d = end_q;
    if (ctl_i.end_add) end_d = end_q + StartW'(need_q + (SizeW+1)'(HeaderBytes));
    idx_d = idx_q;
    if (ctl_i.idx_clr) idx_d = '0;
    if (ctl_i.idx_inc) idx_d = idx_q + 1'b1;
    if (ctl_i.idx_dec) idx_d = idx_q - 1'b1;
    if (ctl_i.idx_pos) idx_d = pos_q;
    if (ctl_i.idx_cnt) idx_d = cnt_q;
    pos_d = pos_q;
    if (ctl_i.pos_idx)  pos_d = idx_q;
    if (ctl_i.pos_prev) pos_d = pos_q - 1'b1;
  end

  // table port: one write or one read a cycle
  always_comb begin
    we       = 1'b1;
    wdata    = cur_q;
    ram_addr = idx_q;
    if (ctl_i.wr_alloc) begin
      ram_addr = pos_q;
      wdata    = '{start: cur_q.start, len: LenW'(need_q), free: 1'b0};
    end else if (ctl_i.wr_mark) begin
      ram_addr = pos_q;
      wdata    = '{start: cur_q.start, len: cur_q.len, free: 1'b0};
    end else if (ctl_i.wr_free) begin
      ram_addr = pos_q;
      wdata    = '{start: cur_q.start, len: cur_q.len, free: 1'b1};
    end else if (ctl_i.wr_shift) begin
      ram_addr = idx_q + 1'b1;
      wdata    = rdata;
    end else if (ctl_i.wr_rem) begin
      ram_addr = pos_q + 1'b1;
      wdata    = '{start: StartW'(cur_q.start + StartW'(HeaderBytes) + StartW'(need_q)),
                   len:   LenW'(cur_q.len - LenW'(need_q) - LenW'(HeaderBytes)),
                   free:  1'b1};
    end else if (ctl_i.wr_app) begin
      ram_addr = cnt_q;
      wdata    = '{start: end_q, len: LenW'(need_q), free: 1'b0};
    end else if (ctl_i.wr_grow) begin
      ram_addr = pos_q;
      wdata    = '{start: cur_q.start,
                   len: LenW'(cur_q.len + LenW'(HeaderBytes) + rdata.len), free: 1'b1};
    end else if (ctl_i.wr_down) begin
      ram_addr = idx_q;
      wdata    = rdata;
    end else begin
      we = 1'b0;
      if (ctl_i.rd_idx1) ram_addr = idx_q + 1'b1;
    end
  end

  ffha_ram #(.Width(EntryW), .Depth(MaxBlocks)) u_table (
    .clk_i  (clk_i),
    .we_i   (we),
    .addr_i (ram_addr[IdxW-1:0]),
    .wdata_i(wdata),
    .rdata_o(rdata)
  );

  // status to controller
  always_comb begin
    sts_o.is_free_req = type_q;
    sts_o.zero_size   = zero_q;
    sts_o.null_addr   = (addr_q == '0);
    sts_o.idx_at_cnt  = (idx_q == cnt_q);
    sts_o.idx1_at_cnt = ((idx_q + 1'b1) >= cnt_q);
    sts_o.idx_gt_pos  = (idx_q > (pos_q + 1'b1));
    sts_o.fits        = rdata.free && ({2'b0, rdata.len} >= need_q);
    sts_o.can_split   = ({2'b0, cur_q.len} > need_q + (SizeW+1)'(HeaderBytes + AlignBytes));
    sts_o.cnt_full    = (cnt_q >= CntW'(MaxBlocks));
    sts_o.app_ok      = ({1'b0, end_q} + {1'b0, StartW'(need_q)} + (StartW+1)'(HeaderBytes)
                         <= (StartW+1)'(HeapBytes)) && !need_q[SizeW]
                        && (cnt_q < CntW'(MaxBlocks));
    sts_o.addr_hit    = ({3'b0, rdata.start} + (StartW+3)'(HeaderBytes))
                        == (StartW+3)'(addr_q);
    sts_o.rd_free     = rdata.free;
    sts_o.pos_zero    = (pos_q == '0);
  end

  assign result_addr_o = res_q;

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(MaxBlocks)) else $error("block count beyond table");
  a_end_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, end_q} <= (StartW+1)'(HeapBytes)) else $error("heap end beyond heap");
  a_one_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ctl_i.cnt_inc && ctl_i.cnt_dec)) else $error("count up and down together");
`endif

endmodule

>>> hdl/ffha_ctrl.sv
// controller: sequences table walks, shifts and merges for one request
module ffha_ctrl
  import ffha_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start_i,
  input  sts_t    sts_i,
  output ctl_t    ctl_o,
  output logic    busy_o
);

  state_e  state_q, state_d;
  status_e stat_q, stat_d;
  logic    prev_q, prev_d;  // merging into predecessor

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      stat_q  <= ST_OK;
      prev_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      stat_q  <= stat_d;
      prev_q  <= prev_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    stat_d  = stat_q;
    prev_d  = prev_q;
    case (state_q)
      S_IDLE:    if (start_i) state_d = S_A_RD;
      S_A_RD: begin
        // first cycle after capture: dispatch
        stat_d = ST_OK;
        prev_d = 1'b0;
        if (sts_i.is_free_req) begin
          if (sts_i.null_addr) begin
            stat_d = ST_NULL; state_d = S_DONE;
          end else state_d = S_F_RD;
        end else if (sts_i.zero_size) begin
          stat_d = ST_NULL; state_d = S_DONE;
        end else state_d = S_A_WT;
      end
      S_A_WT: state_d = sts_i.idx_at_cnt ? S_A_APP : S_A_CHK;
      S_A_CHK: state_d = sts_i.fits ? S_A_SPLIT : S_A_WT;
      S_A_SPLIT: begin
        if (sts_i.can_split && !sts_i.cnt_full) state_d = S_A_SH_RD;
        else state_d = S_DONE;
      end
      S_A_SH_RD: state_d = sts_i.idx_gt_pos ? S_A_SH_WT : S_A_INS;
      S_A_SH_WT: state_d = S_A_SH_WR;
      S_A_SH_WR: state_d = S_A_SH_RD;
      S_A_INS:   state_d = S_DONE;
      S_A_APP: begin
        if (!sts_i.app_ok) stat_d = ST_NOMEM;
        state_d = S_DONE;
      end
      S_F_RD: state_d = sts_i.idx_at_cnt ? S_DONE : S_F_WT;
      S_F_WT: state_d = S_F_CHK;
      S_F_CHK: begin
        if (sts_i.addr_hit) state_d = S_M_RD;
        else state_d = S_F_RD;
      end
      S_M_RD: state_d = sts_i.idx1_at_cnt ? S_P_RD : S_M_WT;
      S_M_WT: state_d = S_M_CHK;
      S_M_CHK: state_d = sts_i.rd_free ? S_R_RD : S_P_RD;
      S_R_RD: state_d = sts_i.idx_at_cnt ? S_M_RD : S_R_WT;
      S_R_WT: state_d = S_R_WR;
      S_R_WR: state_d = S_R_RD;
      S_P_RD: begin
        if (prev_q || sts_i.pos_zero) state_d = S_DONE;
        else state_d = S_P_WT;
      end
      S_P_WT: state_d = S_P_CHK;
      S_P_CHK: begin
        if (sts_i.rd_free) begin
          prev_d = 1'b1; state_d = S_M_RD;
        end else state_d = S_DONE;
      end
      S_DONE:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
    if (state_q == S_F_RD && sts_i.idx_at_cnt) stat_d = ST_UNKNOWN;
  end

  // outputs
  always_comb begin
    ctl_o        = '0;
    ctl_o.status = stat_q;
    busy_o       = (state_q != S_IDLE);
    case (state_q)
      S_IDLE: begin
        ctl_o.load = start_i;
        ctl_o.idx_clr = start_i;
      end
      S_A_RD: ctl_o.rd_idx = 1'b1;
      S_A_WT: begin
        // read at idx goes on; its data is checked in S_A_CHK
        ctl_o.hold_rd = 1'b1;
        ctl_o.pos_idx = 1'b1;
      end
      S_A_CHK: begin
        if (sts_i.fits) begin
          ctl_o.hold_rd = 1'b1;
        end else begin
          ctl_o.idx_inc = 1'b1;
        end
      end
      S_A_SPLIT: begin
        ctl_o.res_set = 1'b1;
        if (sts_i.can_split && !sts_i.cnt_full) begin
          ctl_o.wr_alloc = 1'b1;
          ctl_o.idx_cnt  = 1'b1;
        end else begin
          ctl_o.wr_mark = 1'b1;
        end
      end
      S_A_SH_RD: begin
        // idx walks down from count; move idx-1 to idx
        if (sts_i.idx_gt_pos) ctl_o.idx_dec = 1'b1;
      end
      S_A_SH_WT: ;
      S_A_SH_WR: begin
        ctl_o.wr_shift = 1'b1;
      end
      S_A_INS: begin
        ctl_o.wr_rem  = 1'b1;
        ctl_o.cnt_inc = 1'b1;
      end
      S_A_APP: begin
        if (sts_i.app_ok) begin
          ctl_o.hold_rd = 1'b0;
          ctl_o.wr_app  = 1'b1;
          ctl_o.cnt_inc = 1'b1;
          ctl_o.end_add = 1'b1;
          ctl_o.idx_cnt = 1'b1;
        end
      end
      S_F_RD: ctl_o.rd_idx = 1'b1;
      S_F_WT: ;
      S_F_CHK: begin
        if (sts_i.addr_hit) begin
          ctl_o.hold_rd = 1'b1;
          ctl_o.pos_idx = 1'b1;
        end else begin
          ctl_o.idx_inc = 1'b1;
        end
      end
      S_M_RD: begin
        if (sts_i.idx1_at_cnt) ctl_o.wr_free = 1'b1;
        else ctl_o.rd_idx1 = 1'b1;
      end
      S_M_WT: ctl_o.rd_idx1 = 1'b1;
      S_M_CHK: begin
        if (sts_i.rd_free) begin
          // absorb successor, then close the gap from the slot after it
          ctl_o.wr_grow = 1'b1;
          ctl_o.cnt_dec = 1'b1;
          ctl_o.idx_inc = 1'b1;
        end else begin
          ctl_o.wr_free = 1'b1;
        end
      end
      S_R_RD: begin
        if (!sts_i.idx_at_cnt) ctl_o.rd_idx1 = 1'b1;
        else ctl_o.idx_pos = 1'b1;
      end
      S_R_WT: ctl_o.rd_idx1 = 1'b1;
      S_R_WR: begin
        ctl_o.wr_down = 1'b1;
        ctl_o.idx_inc = 1'b1;
      end
      S_P_RD: begin
        if (!(prev_q || sts_i.pos_zero)) begin
          ctl_o.pos_prev = 1'b1;
          ctl_o.idx_dec  = 1'b1;
        end
      end
      S_P_WT: ctl_o.rd_idx = 1'b0;
      S_P_CHK: begin
        ctl_o.hold_rd = sts_i.rd_free;
        ctl_o.idx_pos = 1'b1;
      end
      S_DONE:  ctl_o.done = 1'b1;
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_o.done |-> busy_o) else $error("done while idle");
  a_idle_after: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_o.done |=> !busy_o) else $error("still busy after done");
  a_load_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_o.load |=> (state_q == S_A_RD)) else $error("load without dispatch");
`endif

endmodule

>>> hdl/first_fit_heap_allocator.sv
// top level of the first-fit heap allocator
//
// Usage: drive req_type_i, req_size_i and req_addr_i and raise start_i;
// the word is taken at a clock edge where start_i is high and busy_o is
// low. busy_o stays high while the request walks the block table. When it
// finishes, done_o pulses for one cycle with result_addr_o and status_o;
// the receiver must take that word in that cycle, it cannot stall.
// The first-fit search and the address lookup walk the block table one
// entry at a time; a split that inserts or a merge that removes a table
// entry moves the later entries one by one, and each neighbour is checked
// for merging in turn. All of these steps share the single port of the
// block table memory. One request is handled
// at a time. Reset empties the table and sets the heap end to zero; table
// memory contents are not cleared, only the block count is.
module first_fit_heap_allocator
  import ffha_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  output logic             busy_o,
  input  logic             req_type_i,
  input  logic [SizeW-1:0] req_size_i,
  input  logic [AddrW-1:0] req_addr_i,
  output logic             done_o,
  output logic [AddrW-1:0] result_addr_o,
  output logic [1:0]       status_o
);

  ctl_t ctl;
  sts_t sts;

  ffha_ctrl u_ctrl (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .start_i(start_i),
    .sts_i (sts),
    .ctl_o (ctl),
    .busy_o(busy_o)
  );

  ffha_datapath u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_type_i   (req_type_i),
    .req_size_i   (req_size_i),
    .req_addr_i   (req_addr_i),
    .ctl_i        (ctl),
    .sts_o        (sts),
    .result_addr_o(result_addr_o)
  );

  // result word
  assign done_o   = ctl.done;
  assign status_o = ctl.status;

endmodule

>>> test/first_fit_heap_allocator_tb.sv
// testbench for the first-fit heap allocator: request driver, result monitor, block table predictor
`timescale 1ns / 1ps

module first_fit_heap_allocator_tb;
  import ffha_pkg::*;

  localparam logic ReqAlloc = 1'b0;
  localparam logic ReqFree  = 1'b1;
  localparam int   RunItems = 850;
  localparam longint CycleLimit = 50000000;
  localparam logic [AddrW-1:0] AddrMask = '1;

  typedef struct {
    logic             kind;
    logic [SizeW-1:0] size;
    logic [AddrW-1:0] addr;
  } request_t;

  typedef struct {
    logic             kind;
    logic [AddrW-1:0] addr;
    status_e          status;
  } outcome_t;

  logic             clk_i;
  logic             rst_ni;
  logic             start_i;
  logic             busy_o;
  logic             req_type_i;
  logic [SizeW-1:0] req_size_i;
  logic [AddrW-1:0] req_addr_i;
  logic             done_o;
  logic [AddrW-1:0] result_addr_o;
  logic [1:0]       status_o;

  request_t         pending_q[$];
  outcome_t         outcome_q[$];
  logic [AddrW-1:0] live_addrs[$];
  logic [AddrW-1:0] freed_addrs[$];
  int               error_count;
  int               idle_pct;
  longint           cycle_count;

  // predictor copy of the block table
  longint unsigned  blk_start[MaxBlocks];
  longint unsigned  blk_len[MaxBlocks];
  bit               blk_free[MaxBlocks];
  int               blk_count;
  longint unsigned  heap_top;

  first_fit_heap_allocator uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .req_type_i    (req_type_i),
    .req_size_i    (req_size_i),
    .req_addr_i    (req_addr_i),
    .done_o        (done_o),
    .result_addr_o (result_addr_o),
    .status_o      (status_o)
  );

  // clock and reset
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // open a gap at entry slot: shift entries from slot up by one
  function automatic void table_open(int slot);
    for (int k = blk_count; k > slot; k--) begin
      blk_start[k] = blk_start[k-1];
      blk_len[k]   = blk_len[k-1];
      blk_free[k]  = blk_free[k-1];
    end
    blk_count++;
  endfunction

  // absorb free successors into entry p
  function automatic void absorb_successors(int p);
    while (p + 1 < blk_count && blk_free[p+1]) begin
      blk_len[p] += HeaderBytes + blk_len[p+1];
      for (int k = p + 1; k + 1 < blk_count; k++) begin
        blk_start[k] = blk_start[k+1];
        blk_len[k]   = blk_len[k+1];
        blk_free[k]  = blk_free[k+1];
      end
      blk_count--;
    end
  endfunction

  // work out the outcome of one request and update the table
  function automatic outcome_t heap_outcome(request_t rq);
    outcome_t         res;
    longint unsigned  need;
    longint unsigned  old_len;
    int               hit;
    res.kind   = rq.kind;
    res.addr   = '0;
    res.status = ST_OK;
    hit        = -1;
    if (rq.kind == ReqAlloc) begin
      if (rq.size == 0) begin
        res.status = ST_NULL;
        return res;
      end
      need = ((longint'(rq.size) + AlignBytes - 1) / AlignBytes) * AlignBytes;
      for (int i = 0; i < blk_count && hit < 0; i++) begin
        if (blk_free[i] && blk_len[i] >= need) hit = i;
      end
      if (hit >= 0) begin
        blk_free[hit] = 1'b0;
        if (blk_len[hit] > need + HeaderBytes + AlignBytes && blk_count < MaxBlocks) begin
          old_len = blk_len[hit];
          table_open(hit + 1);
          blk_start[hit+1] = blk_start[hit] + HeaderBytes + need;
          blk_len[hit+1]   = old_len - need - HeaderBytes;
          blk_free[hit+1]  = 1'b1;
          blk_len[hit]     = need;
        end
        res.addr = AddrW'((blk_start[hit] + HeaderBytes) & AddrMask);
        return res;
      end
      if (heap_top + HeaderBytes + need > HeapBytes || blk_count >= MaxBlocks) begin
        res.status = ST_NOMEM;
        return res;
      end
      blk_start[blk_count] = heap_top;
      blk_len[blk_count]   = need;
      blk_free[blk_count]  = 1'b0;
      blk_count++;
      heap_top += HeaderBytes + need;
      res.addr = AddrW'((heap_top - need) & AddrMask);
      return res;
    end
    if (rq.addr == 0) begin
      res.status = ST_NULL;
      return res;
    end
    for (int i = 0; i < blk_count && hit < 0; i++) begin
      if (blk_start[i] + HeaderBytes == rq.addr) hit = i;
    end
    if (hit < 0) begin
      res.status = ST_UNKNOWN;
      return res;
    end
    blk_free[hit] = 1'b1;
    absorb_successors(hit);
    if (hit > 0 && blk_free[hit-1]) absorb_successors(hit - 1);
    return res;
  endfunction

  task automatic report(string what, logic [AddrW-1:0] got, logic [AddrW-1:0] want);
    $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
    error_count++;
  endtask

  // driver: take accepted words into the predictor, present the next word
  always @(posedge clk_i or negedge rst_ni) begin
    request_t rq;
    logic     taken;
    if (!rst_ni) begin
      start_i    <= 1'b0;
      req_type_i <= ReqAlloc;
      req_size_i <= '0;
      req_addr_i <= '0;
      blk_count  = 0;
      heap_top   = 0;
    end else begin
      taken = start_i && !busy_o;
      if (taken) begin
        rq.kind = req_type_i;
        rq.size = req_size_i;
        rq.addr = req_addr_i;
        outcome_q.push_back(heap_outcome(rq));
      end
      if (!start_i || taken) begin
        if (pending_q.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
          rq = pending_q.pop_front();
          req_type_i <= rq.kind;
          req_size_i <= rq.size;
          req_addr_i <= rq.addr;
          start_i    <= 1'b1;
        end else begin
          start_i <= 1'b0;
        end
      end
    end
  end

  // monitor: check each result word against the oldest outcome
  always @(posedge clk_i) begin
    outcome_t want;
    if (rst_ni && done_o) begin
      if (outcome_q.size() == 0) begin
        $display("mismatch at %0t: result word with nothing outstanding", $realtime);
        error_count++;
      end else begin
        want = outcome_q.pop_front();
        if (result_addr_o !== want.addr) report("result_addr", result_addr_o, want.addr);
        if (status_o !== want.status)
          report("status", AddrW'(status_o), AddrW'(want.status));
        if (want.kind == ReqAlloc && want.status == ST_OK && want.addr != 0)
          live_addrs.push_back(want.addr);
      end
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("first_fit_heap_allocator_tb: done, errors");
      $finish;
    end
  end

  task automatic queue_word(logic kind, logic [SizeW-1:0] size, logic [AddrW-1:0] addr);
    request_t rq;
    rq.kind = kind;
    rq.size = size;
    rq.addr = addr;
    pending_q.push_back(rq);
  endtask

  task automatic drain();
    do @(posedge clk_i);
    while (pending_q.size() > 0 || start_i || outcome_q.size() > 0);
  endtask

  // one random word, mostly well-formed alloc and free traffic
  task automatic queue_random();
    int pick;
    int idx;
    logic [AddrW-1:0] a;
    pick = $urandom_range(0, 99);
    if (live_addrs.size() > 60 && pick < 45) pick = 60;
    if (pick < 45) begin
      idx = $urandom_range(0, 99);
      if (idx < 3) queue_word(ReqAlloc, SizeW'($urandom_range(0, 2097151)), AddrW'($urandom));
      else if (idx < 5) queue_word(ReqAlloc, '0, AddrW'($urandom));
      else if (idx < 12)
        queue_word(ReqAlloc, SizeW'($urandom_range(1, 400000)), AddrW'($urandom));
      else queue_word(ReqAlloc, SizeW'($urandom_range(1, 256)), AddrW'($urandom));
    end else if (pick < 85 && live_addrs.size() > 0) begin
      idx = $urandom_range(0, live_addrs.size() - 1);
      a = live_addrs[idx];
      live_addrs.delete(idx);
      freed_addrs.push_back(a);
      if (freed_addrs.size() > 40) void'(freed_addrs.pop_front());
      queue_word(ReqFree, SizeW'($urandom), a);
    end else begin
      idx = $urandom_range(0, 9);
      if (idx < 5 && freed_addrs.size() > 0)
        a = freed_addrs[$urandom_range(0, freed_addrs.size() - 1)];
      else if (idx < 8) a = AddrW'($urandom);
      else a = '0;
      queue_word(ReqFree, SizeW'($urandom), a);
    end
  endtask

  // stimulus and end of run
  initial begin
    int sent;
    error_count = 0;
    cycle_count = 0;
    idle_pct    = 20;
    @(posedge rst_ni);

    // directed: rounding, split, repeated free, merges, null and unknown words
    queue_word(ReqAlloc, 21'd1, '0);
    queue_word(ReqAlloc, 21'd8, '0);
    queue_word(ReqAlloc, 21'd17, '0);
    queue_word(ReqAlloc, 21'd200, '0);
    queue_word(ReqAlloc, 21'd48, '0);
    queue_word(ReqFree, '0, 20'd136);
    queue_word(ReqAlloc, 21'd8, '0);
    queue_word(ReqFree, '0, 20'd56);
    queue_word(ReqFree, '1, 20'd56);
    queue_word(ReqFree, '0, 20'd88);
    queue_word(ReqFree, '0, 20'd24);
    queue_word(ReqAlloc, 21'd64, '1);
    queue_word(ReqFree, '0, 20'd7);
    queue_word(ReqFree, '0, 20'hFFFFF);
    queue_word(ReqFree, '0, '0);
    queue_word(ReqAlloc, '0, '0);
    queue_word(ReqAlloc, 21'd1048576, '0);
    queue_word(ReqAlloc, 21'h1FFFFF, '0);
    queue_word(ReqAlloc, 21'd1048000, '0);
    drain();
    live_addrs.delete();

    // random traffic in short bursts, sender gaps per phase
    sent = 0;
    while (sent < RunItems) begin
      if (sent < RunItems / 3) idle_pct = 20;
      else if (sent < 2 * RunItems / 3) idle_pct = 62;
      else idle_pct = 0;
      for (int n = 0; n < 8; n++) queue_random();
      sent += 8;
      drain();
    end

    repeat (50) @(posedge clk_i);
    if (error_count == 0) $display("first_fit_heap_allocator_tb: done, clean");
    else $display("first_fit_heap_allocator_tb: done, errors");
    $finish;
  end

endmodule

>>> files.f
hdl/ffha_pkg.sv
hdl/ffha_ram.sv
hdl/ffha_datapath.sv
hdl/ffha_ctrl.sv
hdl/first_fit_heap_allocator.sv
test/first_fit_heap_allocator_tb.sv
